[src/distinct_window_marker_finder_defines.svh]
// Assertion macros shared by the modules of the distinct window marker finder.
`ifndef DISTINCT_WINDOW_MARKER_FINDER_DEFINES_SVH
`define DISTINCT_WINDOW_MARKER_FINDER_DEFINES_SVH

`ifndef SYNTHESIS

// Checks a property on every rising clock edge outside reset.
`define DWM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that the consequent holds in the same cycle as the antecedent.
`define DWM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define DWM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define DWM_ASSERT(lbl, clk, rst_n, prop, msg)
`define DWM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define DWM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

[src/dwm_pkg.sv]
`timescale 1ns / 1ps

package dwm_pkg;

    // Alphabet and line limits.
    localparam int ALPHABET_SIZE   = 26;
    localparam int LETTER_W        = 5;
    localparam int MAX_WINDOW      = 16;
    localparam int WIN_W           = 5;
    localparam int MAX_LINE_LENGTH = 8192;
    localparam int POS_W           = 14;

    // Stream data widths, padded to whole bytes.
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 16;

    // Window size after reset.
    localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(4);

    // One accepted symbol.
    typedef struct packed {
        logic [LETTER_W-1:0] letter;
        logic                last_symbol;
    } t_item;

    // One result item.
    typedef struct packed {
        logic             marker_found;
        logic [POS_W-1:0] marker_position;
    } t_result;

    // Maps a written window size onto the supported range.
    function automatic logic [WIN_W-1:0] clamp_window(input logic [WIN_W-1:0] value);
        logic [WIN_W-1:0] w;
        w = value;
        if (value == '0) begin
            w = WIN_W'(1);
        end else if (value > WIN_W'(MAX_WINDOW)) begin
            w = WIN_W'(MAX_WINDOW);
        end
        return w;
    endfunction

endpackage

[src/dwm_in_stage.sv]
`timescale 1ns / 1ps

module dwm_in_stage (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [dwm_pkg::S_TDATA_W-1:0]   i_data,
    input  logic                            i_last,
    input  logic                            i_advance,
    output logic                            o_valid,
    output dwm_pkg::t_item                  o_item
);
    import dwm_pkg::*;

    logic  r_valid;
    t_item r_item;

    // The stage takes a new symbol when empty or when its symbol moves on.
    assign o_ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Symbol register, loaded on every input transfer.
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item.letter      <= i_data[LETTER_W-1:0];
            r_item.last_symbol <= i_last;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

[src/dwm_core.sv]
`timescale 1ns / 1ps
`include "distinct_window_marker_finder_defines.svh"

module dwm_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_clear,
    input  logic [dwm_pkg::WIN_W-1:0]   i_window,
    input  logic                        i_step,
    input  dwm_pkg::t_item              i_item,
    output logic                        o_res_valid,
    output dwm_pkg::t_result            o_result
);
    import dwm_pkg::*;

    // Per-letter position of the latest occurrence in this line.
    logic [POS_W-1:0]         r_last_pos [ALPHABET_SIZE];
    logic [ALPHABET_SIZE-1:0] r_pos_valid;
    // Highest earlier-occurrence position seen so far: a window must start after it.
    logic [POS_W-1:0]         r_bound;
    logic [POS_W-1:0]         r_seen;
    logic                     r_reported;

    logic [LETTER_W-1:0] idx;
    logic                active;
    logic [POS_W-1:0]    pos_next;
    logic [POS_W-1:0]    prev_pos;
    logic [POS_W-1:0]    n_bound;
    logic [POS_W:0]      reach;
    logic                hit;

    // Saturate letters beyond the alphabet onto its last letter.
    assign idx = (i_item.letter >= LETTER_W'(ALPHABET_SIZE)) ?
                 LETTER_W'(ALPHABET_SIZE - 1) : i_item.letter;

    // Scanning stops after a report or once the line is overlong.
    assign active   = !r_reported && (r_seen < POS_W'(MAX_LINE_LENGTH));
    assign pos_next = r_seen + POS_W'(1);
    assign prev_pos = r_pos_valid[idx] ? r_last_pos[idx] : '0;
    assign n_bound  = (prev_pos > r_bound) ? prev_pos : r_bound;

    // The last window_size symbols are distinct when no repeat lies inside them.
    assign reach = {1'b0, n_bound} + (POS_W + 1)'(i_window);
    assign hit   = active && (reach <= {1'b0, pos_next});

    // A found result, or not-found when the line ends without a report.
    always_comb begin
        o_res_valid              = i_step && (hit || (i_item.last_symbol && !r_reported));
        o_result.marker_found    = hit;
        o_result.marker_position = hit ? pos_next : '0;
    end

    // Line state: cleared by reset, by a window write and after the last symbol.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_pos_valid <= '0;
            r_bound     <= '0;
            r_seen      <= '0;
            r_reported  <= 1'b0;
        end else if (i_step) begin
            if (i_item.last_symbol) begin
                r_pos_valid <= '0;
                r_bound     <= '0;
                r_seen      <= '0;
                r_reported  <= 1'b0;
            end else if (active) begin
                r_pos_valid[idx] <= 1'b1;
                r_bound          <= n_bound;
                r_seen           <= pos_next;
                r_reported       <= hit;
            end
        end
    end

    // Position table; entries are only read once their valid bit is set.
    always_ff @(posedge i_clk) begin
        if (i_step && active) begin
            r_last_pos[idx] <= pos_next;
        end
    end

    `DWM_ASSERT_IMP(a_found_after_window, i_clk, i_rst_n, o_res_valid && o_result.marker_found, o_result.marker_position >= POS_W'(i_window), "marker reported before a full window")
    `DWM_ASSERT_NXT(a_line_clears, i_clk, i_rst_n, i_step && i_item.last_symbol, r_seen == '0 && !r_reported && r_pos_valid == '0, "line state not cleared after the last symbol")
    `DWM_ASSERT_IMP(a_report_once, i_clk, i_rst_n, $rose(r_reported), $past(o_res_valid && o_result.marker_found), "report flag set without a found result")
    `DWM_ASSERT(a_silent_after_report, i_clk, i_rst_n, !(r_reported && o_res_valid), "result produced after the line was reported")

endmodule

[src/dwm_out_stage.sv]
`timescale 1ns / 1ps

module dwm_out_stage (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_load,
    input  dwm_pkg::t_result                i_result,
    output logic                            o_free,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic                            o_found,
    output logic [dwm_pkg::M_TDATA_W-1:0]   o_data
);
    import dwm_pkg::*;

    logic    r_valid;
    t_result r_result;

    // The register can take a result when empty or when its result is taken.
    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (i_load && o_free) begin
            r_result <= i_result;
        end
    end

    assign o_valid = r_valid;
    assign o_found = r_result.marker_found;
    assign o_data  = M_TDATA_W'(r_result.marker_position);

endmodule

[src/distinct_window_marker_finder.sv]
// A symbol's transfer loads the input stage; its result is loaded into the output register
// once that register is free, and is then presented on the master side.
// Throughput: one symbol per cycle while the master side takes results; a result waiting
// in the output register holds the input stage.
// Reset (synchronous, active low) empties both stages, clears all line state and sets
// the window size to 4. A window size write also clears the line state.
`timescale 1ns / 1ps

module distinct_window_marker_finder (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Slave side: tdata = letter[4:0], zero padding [7:5]; tlast = last_symbol.
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [dwm_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    input  logic                            s_axis_tlast,
    // Master side: tdata = marker_position[13:0], zero padding [15:14]; tuser = marker_found.
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [dwm_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    output logic                            m_axis_tuser,
    // Window size register write.
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [dwm_pkg::WIN_W-1:0]       i_cfg_data
);
    import dwm_pkg::*;

    logic [WIN_W-1:0] r_win;
    logic             cfg_wr;
    logic             in_valid;
    t_item            in_item;
    logic             out_free;
    logic             step;
    logic             res_valid;
    t_result          result;

    // Window size register holds the clamped value.
    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= WINDOW_RESET;
        end else if (cfg_wr) begin
            r_win <= clamp_window(i_cfg_data);
        end
    end

    // A held symbol is processed whenever the result register can take its result.
    assign step = in_valid && out_free;

    dwm_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_data    (s_axis_tdata),
        .i_last    (s_axis_tlast),
        .i_advance (step),
        .o_valid   (in_valid),
        .o_item    (in_item)
    );

    dwm_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_clear     (cfg_wr),
        .i_window    (r_win),
        .i_step      (step),
        .i_item      (in_item),
        .o_res_valid (res_valid),
        .o_result    (result)
    );

    dwm_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (res_valid),
        .i_result (result),
        .o_free   (out_free),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_found  (m_axis_tuser),
        .o_data   (m_axis_tdata)
    );

endmodule
